>>> sv/sed_pkg.sv
// Package: shared types and constants of the string escape decoder.
package sed_pkg;

    // Decoder mode codes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2
    } mode_t;

    // Character constants
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Octal value holds at most four digits, leading zero included
    localparam logic [2:0] OCTAL_MAX_DIGITS = 3'd4;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // One result word
    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       end_of_string;
    } result_t;

    // Results produced by one decoded byte
    typedef struct packed {
        logic [1:0]       cnt;
        result_t [1:0]    res;
    } dec_out_t;

endpackage

>>> sv/sed_decode.sv
// Escape decode logic and decoder state registers.
module sed_decode
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] byte_in,
    input  logic       last_byte,
    output dec_out_t   dec_out
);

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [7:0] accum_reg;
    logic [7:0] accum_next;
    logic [2:0] digits_reg;
    logic [2:0] digits_next;

    logic [7:0] accum_calc;
    logic [2:0] digits_calc;
    logic       is_octal;
    logic [1:0] cnt;
    logic [1:0] cnt_m1;
    result_t [1:0] res;

    assign is_octal    = (byte_in >= CH_ZERO) && (byte_in <= CH_SEVEN);
    assign accum_calc  = {accum_reg[4:0], 3'b000} + {5'b00000, byte_in[2:0]};
    assign digits_calc = digits_reg + 3'd1;

    // Decode one byte into up to two results and the next state
    always_comb
    begin
        mode_next   = mode_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        cnt         = 2'd0;
        res         = '0;
        cnt_m1      = 2'd0;

        case (mode_reg)
            MODE_ESCAPE:
            begin
                mode_next = MODE_NORMAL;
                case (byte_in)
                    CH_E:         begin res[0] = '{CH_ESC, 1'b1, 1'b0};       cnt = 2'd1; end
                    CH_T:         begin res[0] = '{CH_TAB, 1'b1, 1'b0};       cnt = 2'd1; end
                    CH_N:         begin res[0] = '{CH_LF, 1'b1, 1'b0};        cnt = 2'd1; end
                    CH_R:         begin res[0] = '{CH_CR, 1'b1, 1'b0};        cnt = 2'd1; end
                    CH_BACKSLASH: begin res[0] = '{CH_BACKSLASH, 1'b1, 1'b0}; cnt = 2'd1; end
                    CH_ZERO:
                    begin
                        mode_next   = MODE_OCTAL;
                        accum_next  = 8'd0;
                        digits_next = 3'd1;
                    end
                    default:      begin res[0] = '{byte_in, 1'b1, 1'b0};      cnt = 2'd1; end
                endcase
            end
            MODE_OCTAL:
            begin
                if (is_octal && (digits_reg < OCTAL_MAX_DIGITS))
                begin
                    if (digits_calc >= OCTAL_MAX_DIGITS)
                    begin
                        // Fourth digit completes the value
                        res[0]      = '{accum_calc, 1'b1, 1'b0};
                        cnt         = 2'd1;
                        mode_next   = MODE_NORMAL;
                        accum_next  = 8'd0;
                        digits_next = 3'd0;
                    end
                    else
                    begin
                        accum_next  = accum_calc;
                        digits_next = digits_calc;
                    end
                end
                else
                begin
                    // Close the pending value, then treat the byte as normal
                    res[0]      = '{accum_reg, 1'b1, 1'b0};
                    cnt         = 2'd1;
                    accum_next  = 8'd0;
                    digits_next = 3'd0;
                    if (byte_in == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        res[1]    = '{byte_in, 1'b1, 1'b0};
                        cnt       = 2'd2;
                    end
                end
            end
            default:
            begin
                if (byte_in == CH_BACKSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    res[0]    = '{byte_in, 1'b1, 1'b0};
                    cnt       = 2'd1;
                end
            end
        endcase

        // Flush pending state on the final byte
        if (last_byte)
        begin
            if (mode_next == MODE_OCTAL)
            begin
                res[cnt[0]] = '{accum_next, 1'b1, 1'b0};
                cnt         = cnt + 2'd1;
            end
            if (cnt == 2'd0)
            begin
                res[0] = '{8'd0, 1'b0, 1'b0};
                cnt    = 2'd1;
            end
            cnt_m1 = cnt - 2'd1;
            res[cnt_m1[0]].end_of_string = 1'b1;
            mode_next   = MODE_NORMAL;
            accum_next  = 8'd0;
            digits_next = 3'd0;
        end
    end

    assign dec_out.cnt = cnt;
    assign dec_out.res = res;

    // Advance state on each decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            accum_reg  <= 8'd0;
            digits_reg <= 3'd0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
        end
    end

    // A final byte always yields at least one result
    a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |-> (cnt != 2'd0))
        else $error("final byte produced no result");

endmodule

>>> sv/sed_result_queue.sv
// Result queue: takes up to two result words per cycle, delivers one per cycle while m_tready is high.
module sed_result_queue
    import sed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dec_out_t dec_out,
    output logic     space_ok,
    output logic     m_tvalid,
    input  logic     m_tready,
    output result_t  m_word
);

    result_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic [1:0]           push_cnt;
    logic                 pop;

    assign push_cnt    = push ? dec_out.cnt : 2'd0;
    assign pop         = m_tvalid && m_tready;
    assign space_ok    = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign m_tvalid    = (count_reg != '0);
    assign m_word      = mem[rd_ptr_reg];
    assign wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
    assign count_next  = count_reg + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);

    // Store incoming words
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= dec_out.res[0];
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + Q_PTR_W'(1)] <= dec_out.res[1];
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> space_ok)
        else $error("push without room");

    a_double_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2 && !pop) |=> (count_reg == $past(count_reg) + Q_CNT_W'(2)))
        else $error("double push lost a word");

endmodule

>>> sv/string_escape_decoder.sv
// A byte accepted at an edge is held in the input register, decoded once the queue has room, and
// queued; its first result then shows on m_tvalid and a second result, if any, follows.
// Throughput: one byte per cycle, set by the single decode stage and a four-word
// result queue that admits a byte whenever two words are free.
// Reset: rst_n clears the input stage, decoder mode and octal state, and the queue.
module string_escape_decoder
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tuser,   // char_valid
    output logic       m_tlast    // end_of_string
);

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       space_ok;
    logic       fire;
    dec_out_t   dec_out;
    result_t    m_word;

    // Decode the held word once the queue has room for two results
    assign fire     = in_vld_reg && space_ok;
    assign s_tready = !in_vld_reg || space_ok;

    // Hold the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    sed_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_in   (in_byte_reg),
        .last_byte (in_last_reg),
        .dec_out   (dec_out)
    );

    sed_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fire),
        .dec_out  (dec_out),
        .space_ok (space_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_word   (m_word)
    );

    assign m_tdata = m_word.char_out;
    assign m_tuser = m_word.char_valid;
    assign m_tlast = m_word.end_of_string;

endmodule

>>> sim/escape_decode_check.sv
// Decode checker: predicts unescaped words from accepted bytes and compares the output words.
module escape_decode_check
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tlast,   // last_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] char_out
    input  logic       m_tuser,   // char_valid
    input  logic       m_tlast,   // end_of_string
    output int         mismatch_count,
    output int         words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow decoder state
    mode_t      dec_mode;
    logic [7:0] oct_value;
    logic [2:0] oct_digits;

    // Words caused by the byte being decoded, then the words still owed by the block
    result_t    step_words [0:1];
    int         step_count;
    result_t    expected_words [$];

    result_t    got;
    result_t    want;

    task automatic add_word(input logic [7:0] ch, input logic valid);
        step_words[step_count].char_out      = ch;
        step_words[step_count].char_valid    = valid;
        step_words[step_count].end_of_string = 1'b0;
        step_count = step_count + 1;
    endtask

    task automatic clear_octal();
        dec_mode   = MODE_NORMAL;
        oct_value  = 8'd0;
        oct_digits = 3'd0;
    endtask

    // Plain byte: a backslash opens an escape, anything else passes through
    task automatic take_plain(input logic [7:0] b);
        if (b == CH_BACKSLASH)
            dec_mode = MODE_ESCAPE;
        else
            add_word(b, 1'b1);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        step_count = 0;
        if (dec_mode == MODE_ESCAPE)
        begin
            dec_mode = MODE_NORMAL;
            case (b)
                CH_E:         add_word(CH_ESC, 1'b1);
                CH_T:         add_word(CH_TAB, 1'b1);
                CH_N:         add_word(CH_LF, 1'b1);
                CH_R:         add_word(CH_CR, 1'b1);
                CH_BACKSLASH: add_word(CH_BACKSLASH, 1'b1);
                CH_ZERO:
                begin
                    dec_mode   = MODE_OCTAL;
                    oct_value  = 8'd0;
                    oct_digits = 3'd1;
                end
                default:      add_word(b, 1'b1);
            endcase
        end
        else if (dec_mode == MODE_OCTAL)
        begin
            if (b >= CH_ZERO && b <= CH_SEVEN && oct_digits < OCTAL_MAX_DIGITS)
            begin
                // Shift in one octal digit, keep the low eight bits
                oct_value  = {oct_value[4:0], b[2:0]};
                oct_digits = oct_digits + 3'd1;
                if (oct_digits == OCTAL_MAX_DIGITS)
                begin
                    add_word(oct_value, 1'b1);
                    clear_octal();
                end
            end
            else
            begin
                // Close the value, then treat the byte as ordinary text
                add_word(oct_value, 1'b1);
                clear_octal();
                take_plain(b);
            end
        end
        else
        begin
            dec_mode = MODE_NORMAL;
            take_plain(b);
        end

        // Flush at the end of the string; mark the last word
        if (last)
        begin
            if (dec_mode == MODE_OCTAL)
                add_word(oct_value, 1'b1);
            if (step_count == 0)
                add_word(8'd0, 1'b0);
            step_words[step_count - 1].end_of_string = 1'b1;
            clear_octal();
        end

        for (int i = 0; i < step_count; i++)
            expected_words.push_back(step_words[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_octal();
            expected_words.delete();
            mismatch_count = 0;
            words_pending  = 0;
        end
        else
        begin
            // Compare an output word against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.char_out      = m_tdata;
                got.char_valid    = m_tuser;
                got.end_of_string = m_tlast;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual data %h user %b last %b",
                             $time, got.char_out, got.char_valid, got.end_of_string);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.char_out !== want.char_out)
                    begin
                        $display("%0t: char_out mismatch: expected %h, actual %h",
                                 $time, want.char_out, got.char_out);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got.char_valid !== want.char_valid)
                    begin
                        $display("%0t: char_valid mismatch: expected %b, actual %b",
                                 $time, want.char_valid, got.char_valid);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got.end_of_string !== want.end_of_string)
                    begin
                        $display("%0t: end_of_string mismatch: expected %b, actual %b",
                                 $time, want.end_of_string, got.end_of_string);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end

            // Predict the words of an accepted byte
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);

            words_pending = expected_words.size();
        end
    end

endmodule

>>> sim/tb_string_escape_decoder.sv
// Testbench top: drives escaped strings into the decoder with random idling and gives the verdict.
module tb_string_escape_decoder;
    import sed_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int HOLD_CYCLES   = 200;
    localparam int PRESSURE_AT   = 400;
    localparam int DRAIN_CYCLES  = 10;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int         mismatch_count;
    int         words_pending;
    int         bytes_sent;
    logic       src_steady;
    logic       pressure_req;
    logic [7:0] text_bytes [$];

    string_escape_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    escape_decode_check decode_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one byte after an optional gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_steady ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent = bytes_sent + 1;
        @(negedge clk);
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic add_octal_digits(input int n);
        logic [2:0] d;
        for (int i = 0; i < n; i++)
        begin
            d = 3'($urandom_range(0, 7));
            text_bytes.push_back(CH_ZERO + {5'b00000, d});
        end
    endtask

    // Build one string of well-formed pieces with some noise and broken endings
    task automatic build_text();
        int pieces;
        int kind;
        logic [7:0] b;
        text_bytes.delete();
        pieces = $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_BACKSLASH)
                    text_bytes.push_back(CH_BACKSLASH);
                text_bytes.push_back(b);
            end
            else if (kind < 55)
            begin
                text_bytes.push_back(CH_BACKSLASH);
                case ($urandom_range(0, 4))
                    0:       text_bytes.push_back(CH_E);
                    1:       text_bytes.push_back(CH_T);
                    2:       text_bytes.push_back(CH_N);
                    3:       text_bytes.push_back(CH_R);
                    default: text_bytes.push_back(CH_BACKSLASH);
                endcase
            end
            else if (kind < 65)
            begin
                text_bytes.push_back(CH_BACKSLASH);
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind < 90)
            begin
                text_bytes.push_back(CH_BACKSLASH);
                text_bytes.push_back(CH_ZERO);
                add_octal_digits($urandom_range(0, 4));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    text_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        // Leave a lone backslash or an open octal value at the end
        kind = $urandom_range(0, 99);
        if (kind < 8)
            text_bytes.push_back(CH_BACKSLASH);
        else if (kind < 16)
        begin
            text_bytes.push_back(CH_BACKSLASH);
            text_bytes.push_back(CH_ZERO);
            add_octal_digits($urandom_range(0, 2));
        end
    endtask

    // Receiver: random stalls, idle-free stretches, one long hold-off on request
    initial
    begin
        int idle_left;
        int stretch_left;
        logic sink_steady;
        idle_left    = 0;
        stretch_left = 0;
        sink_steady  = 1'b0;
        m_tready     = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_req)
            begin
                pressure_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stretch_left == 0)
            begin
                sink_steady  = ($urandom_range(0, 3) == 0);
                stretch_left = $urandom_range(20, 80);
            end
            stretch_left = stretch_left - 1;
            if (idle_left == 0 && !sink_steady)
                idle_left = idle_length();
            if (idle_left > 0)
            begin
                idle_left = idle_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Sender: reset, directed strings, random strings, drain, verdict
    initial
    begin
        logic pressure_done;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        s_tlast      = 1'b0;
        bytes_sent   = 0;
        src_steady   = 1'b0;
        pressure_req = 1'b0;
        pressure_done = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every named escape, then an escape of an ordinary letter
        send_literal("\\e\\t\\n\\r\\\\\\q");
        // Four octal digits overflow to the full byte value
        send_literal("\\0777");
        // Non-octal byte right after the leading zero closes a zero value
        send_literal("\\0x");
        // Open octal value flushed by the end of string
        send_literal("\\01");
        // Lone backslash at the end leaves only the end marker
        send_literal("\\");
        // Byte extremes pass through as ordinary text
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Random strings
        while (bytes_sent < RANDOM_ITEMS)
        begin
            if (!pressure_done && bytes_sent >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                pressure_req  = 1'b1;
                src_steady    = 1'b1;
            end
            else
                src_steady = ($urandom_range(0, 3) == 0);
            build_text();
            send_text();
        end

        // Drain the outstanding words
        s_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
